// ===== rtl/tetord_pkg.sv =====
// Shared types, constants, rounding and saturation helpers for the tetrahedral order neighbour term.
// No dependencies.
`timescale 1ns / 1ps

package tetord_pkg;

	typedef logic [16:0]        weight_t;
	typedef logic signed [23:0] dist_t;
	typedef logic signed [21:0] term_t;
	typedef logic signed [31:0] grad_t;

	// fraction bits of the unit vector values
	localparam int UNIT_BITS  = 24;
	// square root: one result bit per stage
	localparam int SQRT_STEPS = 32;
	// quotient bits of the unit divisions and of the gradient divisions
	localparam int UNIT_QBITS = 26;
	localparam int GRAD_QBITS = 32;

	// shift right by sh, rounding half away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned sh);
		logic        neg;
		logic [63:0] mag;
		neg = v[63];
		mag = neg ? 64'(-v) : 64'(v);
		if (sh == 0) begin
			return v;
		end
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// saturate to the 22-bit term range
	function automatic term_t sat_term(input logic signed [63:0] v);
		if (v > 64'sd2097151) begin
			return term_t'(22'h1FFFFF);
		end else if (v < -64'sd2097152) begin
			return term_t'(22'h200000);
		end
		return term_t'(v[21:0]);
	endfunction

endpackage

// ===== rtl/tetord_in_if.sv =====
// Input channel: one neighbour (weight and distance vector) per transaction.
// Depends on tetord_pkg.
`timescale 1ns / 1ps

interface tetord_in_if;
	logic              valid;
	logic              ready;
	tetord_pkg::weight_t weight;
	tetord_pkg::dist_t   dist_x;
	tetord_pkg::dist_t   dist_y;
	tetord_pkg::dist_t   dist_z;

	modport source (output valid, weight, dist_x, dist_y, dist_z, input ready);
	modport sink   (input valid, weight, dist_x, dist_y, dist_z, output ready);
endinterface

// ===== rtl/tetord_out_if.sv =====
// Output channel: term values and weighted gradient per transaction.
// Depends on tetord_pkg.
`timescale 1ns / 1ps

interface tetord_out_if;
	logic              valid;
	logic              ready;
	tetord_pkg::term_t value_term;
	tetord_pkg::term_t weight_grad;
	tetord_pkg::grad_t grad_x;
	tetord_pkg::grad_t grad_y;
	tetord_pkg::grad_t grad_z;
	logic              zero_length;

	modport source (output valid, value_term, weight_grad, grad_x, grad_y, grad_z,
		zero_length, input ready);
	modport sink   (input valid, value_term, weight_grad, grad_x, grad_y, grad_z,
		zero_length, output ready);
endinterface

// ===== rtl/tetord_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Flags overflow when the quotient does not fit in QB bits. No dependencies.
`timescale 1ns / 1ps

module tetord_div #(
	parameter int NW = 59,
	parameter int DW = 33,
	parameter int QB = 26
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic          ovf
);

	localparam int HW = NW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [DW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] lo_s  [QB];
	logic [QB-1:0] q_s   [QB];
	logic          ovf_s [QB];

	logic [HW-1:0] hi;
	logic          ovf0;

	// upper part must stay below the divisor for the quotient to fit
	assign hi   = num[NW-1:QB];
	assign ovf0 = CW'(hi) >= CW'(den);

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QB-1:0] lo_i;
		logic [QB-1:0] q_i;
		logic          ovf_i;
		logic [DW:0]   tv;
		logic [DW:0]   diff;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_i = DW'(hi);
			assign den_i = den;
			assign lo_i  = num[QB-1:0];
			assign q_i   = '0;
			assign ovf_i = ovf0;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign den_i = den_s[j-1];
			assign lo_i  = lo_s[j-1];
			assign q_i   = q_s[j-1];
			assign ovf_i = ovf_s[j-1];
		end

		// trial subtract of the divisor
		assign tv   = {rem_i, lo_i[QB-1-j]};
		assign ge   = tv >= {1'b0, den_i};
		assign diff = tv - {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? diff[DW-1:0] : tv[DW-1:0];
				q_s[j]   <= {q_i[QB-2:0], ge};
				lo_s[j]  <= lo_i;
				den_s[j] <= den_i;
				ovf_s[j] <= ovf_i;
			end
		end
	end

	assign quo = q_s[QB-1];
	assign ovf = ovf_s[QB-1];

endmodule

// ===== rtl/tetrahedral_order_neighbor_term_core.sv =====
// Accepts one transaction per cycle while the output is not stalled.
// Depth is set by the 32-stage square root, the 26-stage unit dividers and the
// 32-stage gradient dividers. A stalled output freezes the whole pipeline.
// Reset (arst_n, asynchronous) clears the stage valid bits only.
// Depends on tetord_pkg, tetord_in_if, tetord_out_if, tetord_div.
`timescale 1ns / 1ps

module tetrahedral_order_neighbor_term_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tetord_in_if.sink     nbr,
	tetord_out_if.source  term
);

	localparam int SQ    = tetord_pkg::SQRT_STEPS;
	localparam int UQ    = tetord_pkg::UNIT_QBITS;
	localparam int GQ    = tetord_pkg::GRAD_QBITS;
	localparam int UB    = tetord_pkg::UNIT_BITS;
	localparam int LAT   = 3 + SQ + 1 + UQ + 8 + GQ + 1;
	localparam int VT_SH = 16 + UB - FRAC_BITS;
	localparam int WG_SH = UB - FRAC_BITS;
	localparam int GS    = 2 * FRAC_BITS - 2 * UB + 16;
	localparam int SP    = (GS > 0) ? GS : 0;
	localparam int SN    = (GS < 0) ? -GS : 0;
	localparam int MW    = 50;
	localparam int GNA   = MW + 1 + SP;
	localparam int GNB   = 32 + SN;
	localparam int GNW   = ((GNA > GNB) ? GNA : GNB) + 1;
	localparam int GDW   = 33 + SN;
	localparam int UNW   = 59;
	localparam int UDW   = 33;

	typedef struct packed {
		tetord_pkg::weight_t w;
		tetord_pkg::dist_t   x;
		tetord_pkg::dist_t   y;
		tetord_pkg::dist_t   z;
		logic                zero;
	} sq_side_t;

	typedef struct packed {
		tetord_pkg::weight_t w;
		logic [6:0]          neg;
		logic                zero;
		logic [31:0]         root;
	} ud_side_t;

	typedef struct packed {
		logic [2:0]        neg;
		tetord_pkg::term_t vt;
		tetord_pkg::term_t wg;
		logic              zero;
	} gd_side_t;

	logic           en;
	logic [LAT-1:0] vld_s;

	// whole pipeline advances unless the output holds an untaken result
	assign en        = ~vld_s[LAT-1] | term.ready;
	assign nbr.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], nbr.valid};
		end
	end

	// stages 1 to 3: capture, squares, squared length
	tetord_pkg::weight_t w_s1, w_s2, w_s3;
	tetord_pkg::dist_t   x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
	logic [46:0]         sqx_s2, sqy_s2, sqz_s2;
	logic [47:0]         r2_s3;
	logic                zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1    <= nbr.weight;
			x_s1    <= nbr.dist_x;
			y_s1    <= nbr.dist_y;
			z_s1    <= nbr.dist_z;
			sqx_s2  <= 47'(x_s1 * x_s1);
			sqy_s2  <= 47'(y_s1 * y_s1);
			sqz_s2  <= 47'(z_s1 * z_s1);
			w_s2    <= w_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			r2_s3   <= 48'(sqx_s2) + 48'(sqy_s2) + 48'(sqz_s2);
			zero_s3 <= (x_s2 == '0) && (y_s2 == '0) && (z_s2 == '0);
			w_s3    <= w_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
		end
	end

	// square root of r2 * 2^16, one root bit per stage
	logic [33:0] sq_rem_s  [SQ];
	logic [31:0] sq_root_s [SQ];
	logic [63:0] sq_rad_s  [SQ];
	sq_side_t    sq_side_s [SQ];

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		logic [33:0] rem_i;
		logic [31:0] root_i;
		logic [63:0] rad_i;
		sq_side_t    side_i;
		logic [35:0] tv;
		logic [35:0] trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = {r2_s3, 16'b0};
			assign side_i = '{w_s3, x_s3, y_s3, z_s3, zero_s3};
		end else begin : g_next
			assign rem_i  = sq_rem_s[j-1];
			assign root_i = sq_root_s[j-1];
			assign rad_i  = sq_rad_s[j-1];
			assign side_i = sq_side_s[j-1];
		end

		assign tv    = {rem_i, rad_i[63:62]};
		assign trial = {2'b00, root_i, 2'b01};
		assign ge    = tv >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j]  <= ge ? 34'(tv - trial) : 34'(tv);
				sq_root_s[j] <= {root_i[30:0], ge};
				sq_rad_s[j]  <= {rad_i[61:0], 2'b00};
				sq_side_s[j] <= side_i;
			end
		end
	end

	// stage 4: projections and component magnitudes, dividend set-up
	sq_side_t            sq_out;
	logic [31:0]         root_c;
	logic signed [25:0]  pv [7];
	logic [24:0]         pmag [7];
	logic [UNW-1:0]      num_s4 [7];
	logic [UDW-1:0]      den_s4;
	logic [6:0]          neg_s4;
	tetord_pkg::weight_t w_s4;
	logic                zero_s4;
	logic [31:0]         root_s4;

	assign sq_out = sq_side_s[SQ-1];
	assign root_c = sq_root_s[SQ-1];

	always_comb begin
		pv[0] = 26'(sq_out.x) + 26'(sq_out.y) + 26'(sq_out.z);
		pv[1] = 26'(sq_out.x) - 26'(sq_out.y) - 26'(sq_out.z);
		pv[2] = 26'(sq_out.y) - 26'(sq_out.x) - 26'(sq_out.z);
		pv[3] = 26'(sq_out.z) - 26'(sq_out.x) - 26'(sq_out.y);
		pv[4] = 26'(sq_out.x);
		pv[5] = 26'(sq_out.y);
		pv[6] = 26'(sq_out.z);
		for (int k = 0; k < 7; k++) begin
			pmag[k] = pv[k][25] ? 25'(-pv[k]) : 25'(pv[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 7; k++) begin
				num_s4[k] <= UNW'({pmag[k], 33'b0}) + UNW'(root_c);
				neg_s4[k] <= pv[k][25];
			end
			den_s4  <= {root_c, 1'b0};
			w_s4    <= sq_out.w;
			zero_s4 <= sq_out.zero;
			root_s4 <= root_c;
		end
	end

	// unit values: four projections and three components over r
	logic [UQ-1:0] uq [7];
	ud_side_t      ud_side_s [UQ];

	for (genvar k = 0; k < 7; k++) begin : g_udiv
		tetord_div #(
			.NW (UNW),
			.DW (UDW),
			.QB (UQ)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[k]),
			.den (den_s4),
			.quo (uq[k]),
			.ovf ()
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ud_side_s[0] <= '{w_s4, neg_s4, zero_s4, root_s4};
			for (int i = 1; i < UQ; i++) begin
				ud_side_s[i] <= ud_side_s[i-1];
			end
		end
	end

	// stages 5 to 12: powers, term sum, gradient numerators
	ud_side_t            ud_out;
	logic signed [26:0]  u_s5 [4], u_s6 [4];
	logic signed [26:0]  n_s5 [3], n_s6 [3], n_s7 [3], n_s8 [3];
	logic signed [53:0]  uu_s6 [4];
	logic signed [26:0]  u2c [4];
	logic signed [26:0]  u2_s7 [4];
	logic signed [53:0]  uuu_s7 [4];
	logic signed [27:0]  u3c [4];
	logic signed [29:0]  t_s8, t_s9;
	logic signed [29:0]  as_s8 [3], as_s9 [3];
	logic signed [56:0]  tn_s9 [3];
	logic signed [47:0]  wt_s9;
	logic signed [31:0]  a_s10 [3];
	logic signed [49:0]  wa_s11 [3];
	logic signed [51:0]  p3c [3];
	logic [MW-1:0]       gmag [3];
	tetord_pkg::term_t   vt_s10, vt_s11, vt_s12, wg_s10, wg_s11, wg_s12;
	tetord_pkg::weight_t w_s5, w_s6, w_s7, w_s8, w_s9, w_s10;
	logic                zero_s5, zero_s6, zero_s7, zero_s8, zero_s9, zero_s10;
	logic                zero_s11, zero_s12;
	logic [31:0]         root_s5, root_s6, root_s7, root_s8, root_s9, root_s10, root_s11;
	logic [GNW-1:0]      num_s12 [3];
	logic [GDW-1:0]      den_s12;
	logic [2:0]          neg_s12;

	assign ud_out = ud_side_s[UQ-1];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			u2c[k] = 27'(tetord_pkg::rnd_shr(64'(uu_s6[k]), UB));
			u3c[k] = 28'(tetord_pkg::rnd_shr(64'(uuu_s7[k]), UB));
		end
		for (int c = 0; c < 3; c++) begin
			p3c[c]  = (52'(wa_s11[c]) <<< 1) + 52'(wa_s11[c]);
			gmag[c] = p3c[c][51] ? MW'(-p3c[c]) : MW'(p3c[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// signed unit values
			for (int k = 0; k < 4; k++) begin
				u_s5[k] <= ud_out.neg[k] ? -27'(uq[k]) : 27'(uq[k]);
			end
			for (int c = 0; c < 3; c++) begin
				n_s5[c] <= ud_out.neg[4+c] ? -27'(uq[4+c]) : 27'(uq[4+c]);
			end
			w_s5    <= ud_out.w;
			zero_s5 <= ud_out.zero;
			root_s5 <= ud_out.root;

			// squares
			for (int k = 0; k < 4; k++) begin
				uu_s6[k] <= u_s5[k] * u_s5[k];
			end
			u_s6    <= u_s5;
			n_s6    <= n_s5;
			w_s6    <= w_s5;
			zero_s6 <= zero_s5;
			root_s6 <= root_s5;

			// cubes
			for (int k = 0; k < 4; k++) begin
				u2_s7[k]  <= u2c[k];
				uuu_s7[k] <= u2c[k] * u_s6[k];
			end
			n_s7    <= n_s6;
			w_s7    <= w_s6;
			zero_s7 <= zero_s6;
			root_s7 <= root_s6;

			// term sum and signed sums of squares per component
			t_s8     <= 30'(u3c[0]) + 30'(u3c[1]) + 30'(u3c[2]) + 30'(u3c[3]);
			as_s8[0] <= 30'(u2_s7[0]) + 30'(u2_s7[1]) - 30'(u2_s7[2]) - 30'(u2_s7[3]);
			as_s8[1] <= 30'(u2_s7[0]) - 30'(u2_s7[1]) + 30'(u2_s7[2]) - 30'(u2_s7[3]);
			as_s8[2] <= 30'(u2_s7[0]) - 30'(u2_s7[1]) - 30'(u2_s7[2]) + 30'(u2_s7[3]);
			n_s8     <= n_s7;
			w_s8     <= w_s7;
			zero_s8  <= zero_s7;
			root_s8  <= root_s7;

			// T * N and w * T
			for (int c = 0; c < 3; c++) begin
				tn_s9[c] <= t_s8 * n_s8[c];
			end
			wt_s9   <= $signed({1'b0, w_s8}) * t_s8;
			as_s9   <= as_s8;
			t_s9    <= t_s8;
			w_s9    <= w_s8;
			zero_s9 <= zero_s8;
			root_s9 <= root_s8;

			// gradient sums and the two term outputs
			for (int c = 0; c < 3; c++) begin
				a_s10[c] <= 32'(64'(as_s9[c]) - tetord_pkg::rnd_shr(64'(tn_s9[c]), UB));
			end
			vt_s10   <= tetord_pkg::sat_term(tetord_pkg::rnd_shr(64'(wt_s9), VT_SH));
			wg_s10   <= tetord_pkg::sat_term(tetord_pkg::rnd_shr(64'(t_s9), WG_SH));
			w_s10    <= w_s9;
			zero_s10 <= zero_s9;
			root_s10 <= root_s9;

			// weight times gradient sum
			for (int c = 0; c < 3; c++) begin
				wa_s11[c] <= $signed({1'b0, w_s10}) * a_s10[c];
			end
			vt_s11   <= vt_s10;
			wg_s11   <= wg_s10;
			zero_s11 <= zero_s10;
			root_s11 <= root_s10;

			// gradient dividend: 3*w*A scaled, plus half divisor for rounding
			for (int c = 0; c < 3; c++) begin
				num_s12[c] <= (GNW'(gmag[c]) << (SP + 1)) + (GNW'(root_s11) << SN);
				neg_s12[c] <= p3c[c][51];
			end
			den_s12  <= GDW'(root_s11) << (SN + 1);
			vt_s12   <= vt_s11;
			wg_s12   <= wg_s11;
			zero_s12 <= zero_s11;
		end
	end

	// gradient divisions by r with saturation detect
	logic [GQ-1:0] gq [3];
	logic [2:0]    govf;
	gd_side_t      gd_side_s [GQ];

	for (genvar c = 0; c < 3; c++) begin : g_gdiv
		tetord_div #(
			.NW (GNW),
			.DW (GDW),
			.QB (GQ)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s12[c]),
			.den (den_s12),
			.quo (gq[c]),
			.ovf (govf[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gd_side_s[0] <= '{neg_s12, vt_s12, wg_s12, zero_s12};
			for (int i = 1; i < GQ; i++) begin
				gd_side_s[i] <= gd_side_s[i-1];
			end
		end
	end

	// stage 13: saturate, sign, force zero for a zero-length vector
	gd_side_t          gd_out;
	logic [32:0]       gval [3];
	logic [32:0]       glim [3];
	logic [32:0]       gsat [3];
	tetord_pkg::grad_t gres [3];
	tetord_pkg::term_t vt_s13, wg_s13;
	tetord_pkg::grad_t g_s13 [3];
	logic              zero_s13;

	assign gd_out = gd_side_s[GQ-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			gval[c] = govf[c] ? 33'h1_0000_0000 : 33'(gq[c]);
			glim[c] = gd_out.neg[c] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
			gsat[c] = (gval[c] > glim[c]) ? glim[c] : gval[c];
			gres[c] = gd_out.neg[c] ? 32'(-gsat[c]) : gsat[c][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s13 <= gd_out.zero;
			vt_s13   <= gd_out.zero ? '0 : gd_out.vt;
			wg_s13   <= gd_out.zero ? '0 : gd_out.wg;
			for (int c = 0; c < 3; c++) begin
				g_s13[c] <= gd_out.zero ? '0 : gres[c];
			end
		end
	end

	assign term.valid       = vld_s[LAT-1];
	assign term.value_term  = vt_s13;
	assign term.weight_grad = wg_s13;
	assign term.grad_x      = g_s13[0];
	assign term.grad_y      = g_s13[1];
	assign term.grad_z      = g_s13[2];
	assign term.zero_length = zero_s13;

endmodule
